// ----- src/eiac_pkg.sv -----
// Shared types and constants of the edge interval adaptive classifier.
`timescale 1ns / 1ps

package eiac_pkg;

   localparam int INTERVAL_BITS = 24;
   localparam int THRESH_BITS   = 25;
   localparam int COUNT_BITS    = 14;
   localparam int SYMBOL_BITS   = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_SEL_BIT   = 2;

   localparam logic REG_INIT_THRESHOLD = 1'b0;
   localparam logic REG_UNSTABLE_LIMIT = 1'b1;

   localparam logic [THRESH_BITS-1:0] RESET_THRESHOLD = THRESH_BITS'(120000);
   localparam logic [COUNT_BITS-1:0]  RESET_LIMIT     = COUNT_BITS'(16'h2000);
   localparam logic [THRESH_BITS-1:0] THRESH_MAX      = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX       = '1;

   // The band is (85T/150, floor(125T/150)) for threshold T, tested without division.
   localparam int UPPER_NUM = 125;
   localparam int LOWER_NUM = 85;
   localparam int BAND_DEN  = 150;
   localparam int BAND_BITS = (INTERVAL_BITS + 8 > THRESH_BITS + 7) ?
                              INTERVAL_BITS + 8 : THRESH_BITS + 7;

   typedef enum logic {
      ST_RUN,
      ST_DIVIDE
   } ctrl_state_type;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0] symbol;
      logic                   threshold_changed;
      logic [THRESH_BITS-1:0] threshold_now;
   } rsp_item_type;

endpackage

// ----- src/eiac_if.sv -----
// Valid/ready channel interfaces for edge items and classification results.
`timescale 1ns / 1ps

interface eiac_req_if;
   import eiac_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     edge_rising;
   logic [INTERVAL_BITS-1:0] interval;

   modport source (output valid, edge_rising, interval, input ready);
   modport sink   (input valid, edge_rising, interval, output ready);
endinterface

interface eiac_rsp_if;
   import eiac_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SYMBOL_BITS-1:0] symbol;
   logic                   threshold_changed;
   logic [THRESH_BITS-1:0] threshold_now;

   modport source (output valid, symbol, threshold_changed, threshold_now, input ready);
   modport sink   (input valid, symbol, threshold_changed, threshold_now, output ready);
endinterface

// ----- src/eiac_cell.sv -----
// One cell of the interval window: holds an interval and hands it down the row.
`timescale 1ns / 1ps

module eiac_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic [eiac_pkg::INTERVAL_BITS-1:0] d_in,
   output logic [eiac_pkg::INTERVAL_BITS-1:0] q
);
   import eiac_pkg::*;

   logic [INTERVAL_BITS-1:0] value_ff;
   logic [INTERVAL_BITS-1:0] value_in;

   always_comb begin
      value_in = shift_en ? d_in : value_ff;
   end

   // Unwritten window entries count as zero in the sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

// ----- src/eiac_div.sv -----
// Constant divider through reciprocal multiplication; done flags the registered quotient.
`timescale 1ns / 1ps

module eiac_div #(
   parameter int DIVISOR       = 10,
   parameter int DIVIDEND_BITS = 28
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   // With m = ceil(2^(N+l) / d) and l = clog2(d), floor(x*m / 2^(N+l)) equals
   // floor(x / d) for every N-bit x.
   localparam int SHIFT      = DIVIDEND_BITS + $clog2(DIVISOR);
   localparam int RECIP_BITS = DIVIDEND_BITS + 1;
   localparam int PROD_BITS  = DIVIDEND_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

   logic [DIVIDEND_BITS-1:0] dividend_ff, dividend_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic                     loaded_ff;
   logic                     done_ff;

   always_comb begin
      dividend_in = start ? dividend : dividend_ff;
      prod_in     = loaded_ff ? PROD_BITS'(dividend_ff) * PROD_BITS'(RECIP) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         loaded_ff <= start;
         done_ff   <= loaded_ff;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      prod_ff     <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = DIVIDEND_BITS'(prod_ff >> SHIFT);

endmodule

// ----- src/eiac_out_buf.sv -----
// Two-entry result buffer that decouples the result channel from the edge path.
`timescale 1ns / 1ps

module eiac_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  eiac_pkg::rsp_item_type push_item,
   output logic                  full,
   eiac_rsp_if.source            rsp
);
   import eiac_pkg::*;

   localparam logic [1:0] BUF_DEPTH = 2'd2;

   rsp_item_type head_ff, head_in;
   rsp_item_type tail_ff, tail_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push_valid, pop})
         2'b10: begin
            if (count_ff == '0) begin
               head_in = push_item;
            end else begin
               tail_in = push_item;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_item;
            end else begin
               head_in = tail_ff;
               tail_in = push_item;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full                  = count_ff == BUF_DEPTH;
   assign rsp.valid             = count_ff != '0;
   assign rsp.symbol            = head_ff.symbol;
   assign rsp.threshold_changed = head_ff.threshold_changed;
   assign rsp.threshold_now     = head_ff.threshold_now;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> count_ff != BUF_DEPTH)
      else $error("result pushed into a full buffer");

endmodule

// ----- src/edge_interval_adaptive_classifier.sv -----
// Top level: edge interval classifier with adaptive long/short threshold.
//
//  Channel   Direction  Transfer / access           Payload
//  req_ch    in         valid & ready               edge_rising, interval
//  rsp_ch    out        valid & ready               symbol, threshold_changed, threshold_now
//  csr_*     in/out     APB write on psel&penable   initial_threshold (0x0), unstable_limit (0x4)
//
// One edge per cycle while req_ch.ready is high; a result enters the result buffer on its
// transfer, or, for an edge that retunes the threshold, once the divider is done.
// An edge that retunes holds req_ch.ready low while the window mean is formed by a
// reciprocal multiplication and then while the band products refresh.
// After reset and after a write of initial_threshold, ready is low for one cycle while
// the band products refresh. A stalled rsp_ch fills a two-entry buffer, then stops req_ch.
`timescale 1ns / 1ps

module edge_interval_adaptive_classifier #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   eiac_req_if.sink                           req_ch,
   eiac_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [eiac_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [eiac_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [eiac_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import eiac_pkg::*;

   localparam int SUM_BITS  = INTERVAL_BITS + $clog2(WINDOW_LEN);
   localparam int NT_BITS   = INTERVAL_BITS + 1;
   localparam int SAT_BITS  = (NT_BITS > THRESH_BITS) ? NT_BITS : THRESH_BITS;

   // Configuration registers
   logic [THRESH_BITS-1:0] init_thresh_ff;
   logic [COUNT_BITS-1:0]  limit_ff;
   logic                   csr_write;
   logic                   thresh_write;

   // Classifier state
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [BAND_BITS-1:0]   upper_ff, lower_ff;
   logic                   stale_ff;
   logic [SYMBOL_BITS-1:0] pend_symbol_ff;
   ctrl_state_type         state_ff, state_in;

   logic                     req_accept;
   logic [INTERVAL_BITS-1:0] iv;
   logic [INTERVAL_BITS-1:0] tap [WINDOW_LEN];
   logic [BAND_BITS-1:0]     iv_scaled;
   logic                     out_of_band;
   logic                     is_long;
   logic [SYMBOL_BITS-1:0]   symbol;
   logic                     retune;
   logic                     run_mode;

   logic                div_done;
   logic [SUM_BITS-1:0] div_quot;
   logic [NT_BITS-1:0]  mean;
   logic [NT_BITS-1:0]  nt_wide;
   logic [THRESH_BITS-1:0] nt_sat;

   logic         push_valid;
   rsp_item_type push_item;
   logic         buf_full;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready   = 1'b1;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thresh_write = csr_write && (csr_paddr[REG_SEL_BIT] == REG_INIT_THRESHOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         init_thresh_ff <= RESET_THRESHOLD;
         limit_ff       <= RESET_LIMIT;
      end else if (csr_write) begin
         case (csr_paddr[REG_SEL_BIT])
            REG_INIT_THRESHOLD: init_thresh_ff <= csr_pwdata[THRESH_BITS-1:0];
            REG_UNSTABLE_LIMIT: limit_ff       <= csr_pwdata[COUNT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[REG_SEL_BIT])
         REG_INIT_THRESHOLD: csr_prdata = CSR_DATA_BITS'(init_thresh_ff);
         REG_UNSTABLE_LIMIT: csr_prdata = CSR_DATA_BITS'(limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- control FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (req_accept && retune) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_RUN:    run_mode = 1'b1;
         ST_DIVIDE: run_mode = 1'b0;
         default:   run_mode = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ch.ready = run_mode && !stale_ff && !buf_full;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign iv           = req_ch.interval;

   // ------------------------------------------------------- interval window
   generate
      for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
         if (g == 0) begin : g_head
            eiac_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (req_accept),
               .d_in     (iv),
               .q        (tap[g])
            );
         end else begin : g_body
            eiac_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .shift_en (req_accept),
               .d_in     (tap[g-1]),
               .q        (tap[g])
            );
         end
      end
   endgenerate

   // The last cell holds the interval that leaves the window on this transfer.
   assign sum_in = sum_ff - SUM_BITS'(tap[WINDOW_LEN-1]) + SUM_BITS'(iv);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (req_accept) begin
         sum_ff <= sum_in;
      end
   end

   // ------------------------------------------------ classification and band
   // iv >= floor(125T/150) holds exactly when 150*iv + 149 >= 125T,
   // and iv <= floor(85T/150) exactly when 150*iv <= 85T.
   always_ff @(posedge clock) begin
      upper_ff <= BAND_BITS'(thresh_ff) * BAND_BITS'(UPPER_NUM);
      lower_ff <= BAND_BITS'(thresh_ff) * BAND_BITS'(LOWER_NUM);
   end

   always_comb begin
      iv_scaled   = BAND_BITS'(iv) * BAND_BITS'(BAND_DEN);
      out_of_band = ((iv_scaled + BAND_BITS'(BAND_DEN - 1)) >= upper_ff) ||
                    (iv_scaled <= lower_ff);
      is_long     = THRESH_BITS'(iv) > thresh_ff;
      // Upper bit marks a falling edge, lower bit a long interval.
      symbol      = {!req_ch.edge_rising, is_long};
      if (!out_of_band) begin
         count_in = '0;
      end else if (count_ff == COUNT_MAX) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + COUNT_BITS'(1);
      end
      retune = count_in > limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept) begin
         count_ff <= retune ? '0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_symbol_ff <= symbol;
      end
   end

   // ------------------------------------------------------------- retune
   eiac_div #(
      .DIVISOR       (WINDOW_LEN),
      .DIVIDEND_BITS (SUM_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept && retune),
      .dividend (sum_in),
      .done     (div_done),
      .quotient (div_quot)
   );

   // The mean never exceeds the largest interval.
   always_comb begin
      mean    = NT_BITS'(div_quot[INTERVAL_BITS-1:0]);
      nt_wide = mean + (mean >> 1);
      if (SAT_BITS'(nt_wide) > SAT_BITS'(THRESH_MAX)) begin
         nt_sat = THRESH_MAX;
      end else begin
         nt_sat = THRESH_BITS'(nt_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= RESET_THRESHOLD;
         stale_ff  <= 1'b1;
      end else begin
         if (thresh_write) begin
            thresh_ff <= csr_pwdata[THRESH_BITS-1:0];
         end else if (div_done) begin
            thresh_ff <= nt_sat;
         end
         stale_ff <= thresh_write || div_done;
      end
   end

   // ------------------------------------------------------------ results
   always_comb begin
      push_valid = (req_accept && !retune) || div_done;
      if (div_done) begin
         push_item.symbol            = pend_symbol_ff;
         push_item.threshold_changed = 1'b1;
         push_item.threshold_now     = nt_sat;
      end else begin
         push_item.symbol            = symbol;
         push_item.threshold_changed = 1'b0;
         push_item.threshold_now     = thresh_ff;
      end
   end

   eiac_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (buf_full),
      .rsp        (rsp_ch)
   );

   a_no_transfer_while_dividing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !req_accept)
      else $error("edge transferred while the threshold is being retuned");

   a_done_only_when_dividing: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside a retune");

   a_threshold_kept: assert property (@(posedge clock) disable iff (reset)
      req_accept && !retune |=> thresh_ff == $past(thresh_ff))
      else $error("threshold moved on an edge that did not retune it");

endmodule
